/* src/cndf_pkg.sv */
// Shared constants for the cross-neighbor deglitch filter: default sizes,
// action codes, register map and register reset values. No dependencies.
package cndf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // action field codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // register map (word index = paddr[3:2])
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_FRAME_WIDTH      = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_GLITCH_THRESHOLD = 2'd2;

  localparam int CFG_DIM_W = 11;
  localparam int CFG_THR_W = 8;

  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST      = 11'd30;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST     = 11'd20;
  localparam logic [CFG_THR_W-1:0] GLITCH_THRESHOLD_RST = 8'd1;

endpackage

/* src/cndf_pixel_if.sv */
// Input request channel of the deglitch filter: valid/ready plus action and pixel.
// Depends on cndf_pkg.
interface cndf_pixel_if #(
  parameter int PIXEL_BITS = cndf_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, action, pixel_in, input ready);
  modport sink   (input valid, action, pixel_in, output ready);
endinterface

/* src/cndf_result_if.sv */
// Result request channel of the deglitch filter: valid/ready plus filtered pixel
// and flags. Depends on cndf_pkg.
interface cndf_result_if #(
  parameter int PIXEL_BITS = cndf_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  replaced;
  logic                  end_of_frame;

  modport source (output valid, pixel_out, replaced, end_of_frame, input ready);
  modport sink   (input valid, pixel_out, replaced, end_of_frame, output ready);
endinterface

/* src/cross_neighbor_deglitch_filter_top.sv */
// Cross-neighbor deglitch filter, top level: two line memories and a
// three-register pipeline. Depends on cndf_pkg, cndf_pixel_if, cndf_result_if.
//
// Usage:
//  - pixels: raster-order input requests. action = ACT_PIXEL carries a pixel,
//    action = ACT_DRAIN is a drain tick that flushes one pixel of the last row
//    once the whole frame has arrived. Pixels sent while draining and drain
//    ticks sent while not draining are accepted and dropped.
//  - results: one filtered pixel per request, from the second row on, one row
//    late (a pixel leaves once its lower neighbor arrived). end_of_frame marks
//    the last drain result of the frame.
//  - APB: frame_width at 0x0, frame_height at 0x4, glitch_threshold at 0x8.
//    Width and height are used clamped to [2, MAX]. Write only while idle.
// Throughput: one request per clock, sustained while results are taken. The line
// memories are read at accept into the stage-2 registers, the neighbor compare
// and sum take the next register, the divide-by-count rounding the output register.
// Stall: when results.ready is low the output register holds and the pipeline
// fills; pixels.ready drops only once all three registers hold work.
// Reset (rst, synchronous): counters, drain state and pipeline valids clear,
// registers return to 30 x 20, threshold 1. Line memories are not cleared.
module cross_neighbor_deglitch_filter_top #(
  parameter int MAX_WIDTH  = cndf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cndf_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = cndf_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  cndf_pixel_if.sink                        pixels,
  cndf_result_if.source                     results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cndf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cndf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cndf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import cndf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DW_W   = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
                          $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
  localparam int DH_W   = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ?
                          $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;
  localparam int SUM_W  = PIXEL_BITS + 2;
  localparam int CMP_W  = (PIXEL_BITS > CFG_THR_W) ? PIXEL_BITS : CFG_THR_W;
  localparam int PROD_W = 2 * SUM_W;
  // reciprocal of 3 for the three-neighbor average
  localparam logic [SUM_W-1:0] RECIP3 = SUM_W'((2 ** SUM_W) / 3);

  // ---------------------------------------------------------------- config
  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] frame_height;
  logic [CFG_THR_W-1:0] glitch_threshold;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RST;
      frame_height     <= FRAME_HEIGHT_RST;
      glitch_threshold <= GLITCH_THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FRAME_WIDTH:      frame_width      <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:     frame_height     <= pwdata[CFG_DIM_W-1:0];
        REG_GLITCH_THRESHOLD: glitch_threshold <= pwdata[CFG_THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH:      prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT:     prdata = APB_DATA_W'(frame_height);
      REG_GLITCH_THRESHOLD: prdata = APB_DATA_W'(glitch_threshold);
      default:              prdata = '0;
    endcase
  end

  // clamped frame size
  logic [DW_W-1:0] width_raw, eff_w;
  logic [DH_W-1:0] height_raw, eff_h;

  always_comb begin
    width_raw  = DW_W'(frame_width);
    height_raw = DH_W'(frame_height);
    if (width_raw < DW_W'(2))              eff_w = DW_W'(2);
    else if (width_raw > DW_W'(MAX_WIDTH)) eff_w = DW_W'(MAX_WIDTH);
    else                                   eff_w = width_raw;
    if (height_raw < DH_W'(2))               eff_h = DH_W'(2);
    else if (height_raw > DH_W'(MAX_HEIGHT)) eff_h = DH_W'(MAX_HEIGHT);
    else                                     eff_h = height_raw;
  end

  // ---------------------------------------------------------------- control
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [COL_W-1:0] drain_col;
  logic             draining;

  logic             acc, take_pix, take_drain, take;
  logic [COL_W-1:0] col, right_addr;
  logic [DW_W-1:0]  col_plus1;
  logic [DH_W-1:0]  row_plus1;
  logic             row_end, frame_end;

  // pipeline handshake
  logic p2_valid, p3_valid, out_valid;
  logic p2_adv, p3_adv;

  assign p3_adv = p3_valid && (!out_valid || results.ready);
  assign p2_adv = p2_valid && (!p3_valid || p3_adv);
  assign pixels.ready = !p2_valid || p2_adv;

  assign acc        = pixels.valid && pixels.ready;
  assign take_pix   = acc && (pixels.action == ACT_PIXEL) && !draining;
  assign take_drain = acc && (pixels.action == ACT_DRAIN) && draining;
  assign take       = take_pix || take_drain;

  // in_col is zero while draining, drain_col is zero otherwise
  assign col        = draining ? drain_col : in_col;
  assign col_plus1  = DW_W'(col) + DW_W'(1);
  assign right_addr = col_plus1[COL_W-1:0];
  assign row_plus1  = DH_W'(in_row) + DH_W'(1);
  assign row_end    = (col_plus1 >= eff_w);
  assign frame_end  = (row_plus1 >= eff_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row    <= '0;
      in_col    <= '0;
      drain_col <= '0;
      draining  <= 1'b0;
    end else if (take_pix) begin
      if (row_end) begin
        in_col <= '0;
        if (frame_end) begin
          in_row    <= '0;
          draining  <= 1'b1;
          drain_col <= '0;
        end else begin
          in_row <= row_plus1[ROW_W-1:0];
        end
      end else begin
        in_col <= col_plus1[COL_W-1:0];
      end
    end else if (take_drain) begin
      if (row_end) begin
        draining  <= 1'b0;
        drain_col <= '0;
      end else begin
        drain_col <= col_plus1[COL_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- line memories
  // center: pixel row above the incoming one; upper: the row above that.
  // Consecutive requests never share a column, so reads never meet a pending
  // write to the same entry.
  logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] center_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] up_rd, self_rd, right_rd;
  logic                  up_wr;
  logic [COL_W-1:0]      p2_col;

  always_ff @(posedge clk) begin
    if (take) begin
      self_rd  <= center_mem[col];
      right_rd <= center_mem[right_addr];
    end
    if (take_pix) begin
      center_mem[col] <= pixels.pixel_in;
    end
  end

  // the old center pixel moves up once it has been read
  always_ff @(posedge clk) begin
    if (take) begin
      up_rd <= upper_mem[col];
    end
    if (up_wr) begin
      upper_mem[p2_col] <= self_rd;
    end
  end

  // ---------------------------------------------------------------- stage 2: compare, sum
  logic                  p2_pix, p2_produce, p2_eof;
  logic                  p2_has_up, p2_has_left, p2_has_right;
  logic [PIXEL_BITS-1:0] p2_down;
  logic [PIXEL_BITS-1:0] left_pix;

  assign up_wr = p2_adv && p2_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (take) begin
      p2_valid <= 1'b1;
    end else if (p2_adv) begin
      p2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p2_pix       <= take_pix;
      p2_col       <= col;
      p2_down      <= pixels.pixel_in;
      p2_has_up    <= take_drain || (in_row > ROW_W'(1));
      p2_has_left  <= (col != '0);
      p2_has_right <= !row_end;
      p2_produce   <= take_drain || (in_row != '0);
      p2_eof       <= take_drain && row_end;
    end
    // left neighbor is the previous request's own pixel
    if (p2_adv) begin
      left_pix <= self_rd;
    end
  end

  logic [PIXEL_BITS-1:0] nb_val [4];
  logic                  nb_has [4];
  logic [PIXEL_BITS-1:0] diff;
  logic [SUM_W-1:0]      sum;
  logic [2:0]            n_nb;
  logic                  all_far;

  always_comb begin
    nb_val[0] = up_rd;    nb_has[0] = p2_has_up;
    nb_val[1] = p2_down;  nb_has[1] = p2_pix;
    nb_val[2] = left_pix; nb_has[2] = p2_has_left;
    nb_val[3] = right_rd; nb_has[3] = p2_has_right;
    sum     = '0;
    n_nb    = '0;
    all_far = 1'b1;
    diff    = '0;
    for (int k = 0; k < 4; k++) begin
      if (nb_has[k]) begin
        diff = (self_rd > nb_val[k]) ? self_rd - nb_val[k] : nb_val[k] - self_rd;
        if (CMP_W'(diff) <= CMP_W'(glitch_threshold)) all_far = 1'b0;
        sum  = sum + SUM_W'(nb_val[k]);
        n_nb = n_nb + 3'd1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: average
  logic [SUM_W-1:0]      p3_sum;
  logic [2:0]            p3_n;
  logic                  p3_far, p3_eof;
  logic [PIXEL_BITS-1:0] p3_self;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (p2_adv) begin
      p3_valid <= p2_produce;
    end else if (p3_adv) begin
      p3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv) begin
      p3_sum  <= sum;
      p3_n    <= n_nb;
      p3_far  <= all_far;
      p3_eof  <= p2_eof;
      p3_self <= self_rd;
    end
  end

  // round half up: (2s + n) / 2n; for n = 3 that equals (s + 1) / 3
  logic [SUM_W-1:0]  s_inc1, q0, q0_x3, rem3, q3, avg;
  logic [PROD_W-1:0] prod3;
  logic              repl;

  always_comb begin
    s_inc1 = p3_sum + SUM_W'(1);
    prod3  = PROD_W'(s_inc1) * PROD_W'(RECIP3);
    q0     = prod3[PROD_W-1:SUM_W];
    q0_x3  = q0 + (q0 << 1);
    rem3   = s_inc1 - q0_x3;
    q3     = (rem3 >= SUM_W'(3)) ? q0 + SUM_W'(1) : q0;
    unique case (p3_n)
      3'd1:    avg = p3_sum;
      3'd2:    avg = (p3_sum + SUM_W'(1)) >> 1;
      3'd3:    avg = q3;
      3'd4:    avg = (p3_sum + SUM_W'(2)) >> 2;
      default: avg = SUM_W'(p3_self);
    endcase
    repl = p3_far && (p3_n != 3'd0);
  end

  // ---------------------------------------------------------------- output register
  logic [PIXEL_BITS-1:0] out_pix;
  logic                  out_repl, out_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p3_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_adv) begin
      out_pix  <= repl ? avg[PIXEL_BITS-1:0] : p3_self;
      out_repl <= repl;
      out_eof  <= p3_eof;
    end
  end

  assign results.valid        = out_valid;
  assign results.pixel_out    = out_pix;
  assign results.replaced     = out_repl;
  assign results.end_of_frame = out_eof;

  // ---------------------------------------------------------------- checks
  a_drain_at_origin: assert property (@(posedge clk) disable iff (rst)
    draining |-> (in_row == '0) && (in_col == '0))
    else $error("input counters not at frame origin while draining");

  a_drain_col_idle: assert property (@(posedge clk) disable iff (rst)
    !draining |-> (drain_col == '0))
    else $error("drain column moved outside a drain");

  a_two_neighbors: assert property (@(posedge clk) disable iff (rst)
    p3_valid |-> (p3_n >= 3'd2))
    else $error("judged pixel has fewer than two neighbors");

  a_upper_wr_pixel: assert property (@(posedge clk) disable iff (rst)
    up_wr |-> p2_valid && !$past(draining && !take_pix && !take_drain && !p2_valid))
    else $error("upper line written without a pixel in flight");

endmodule
